@@ rtl/scta_pkg.sv @@
// ----------------------------------------------------------------------------
// scta_pkg: shared types and tables for the scan code translator
// Key codes, LED command byte, result record and the two set-1 keymaps.
// ----------------------------------------------------------------------------
package scta_pkg;

  localparam logic [7:0] LED_CMD    = 8'hed;
  localparam logic [7:0] LSHIFT_ON  = 8'h2a;
  localparam logic [7:0] RSHIFT_ON  = 8'h36;
  localparam logic [7:0] LSHIFT_OFF = 8'haa;
  localparam logic [7:0] RSHIFT_OFF = 8'hb6;
  localparam logic [7:0] CAPS_KEY   = 8'h3a;
  localparam logic [7:0] NUM_KEY    = 8'h45;
  localparam logic [7:0] SCROLL_KEY = 8'h46;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5a;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LED  = 1'b1;

  // Translation of one scan code: at most a character or an LED command.
  typedef struct packed {
    logic       char_ok;
    logic [7:0] ch;
    logic       led_ok;
    logic [2:0] leds;
  } res_t;

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFT_MAP [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

endpackage

@@ rtl/scta_translate.sv @@
// ----------------------------------------------------------------------------
// scta_translate: keymap lookup and keyboard state
// Holds shift and lock LED state; translates the staged scan code.
// ----------------------------------------------------------------------------
module scta_translate (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         code,
  input  logic               take,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_leds,
  output scta_pkg::res_t     res
);

  logic [1:0] shift_held;
  logic [2:0] lock_leds;
  logic [1:0] shift_held_next;
  logic [2:0] toggle;
  logic [7:0] raw_ch;
  logic       shifted;

  assign shifted = (shift_held != 2'b00);

  always_comb begin
    raw_ch = 8'h00;
    if (!code[7]) begin
      raw_ch = shifted ? scta_pkg::SHIFT_MAP[code[6:0]] : scta_pkg::PLAIN_MAP[code[6:0]];
    end
  end

  always_comb begin
    toggle = 3'b000;
    unique case (code)
      scta_pkg::CAPS_KEY:   toggle = 3'b100;
      scta_pkg::NUM_KEY:    toggle = 3'b010;
      scta_pkg::SCROLL_KEY: toggle = 3'b001;
      default:              toggle = 3'b000;
    endcase
  end

  always_comb begin
    res.ch = raw_ch;
    // Fold letters to lower case when caps lock and shift agree
    if (raw_ch >= scta_pkg::CHAR_A && raw_ch <= scta_pkg::CHAR_Z &&
        lock_leds[2] == shifted) begin
      res.ch = raw_ch + scta_pkg::CASE_DELTA;
    end
    res.char_ok = (raw_ch != 8'h00);
    res.led_ok  = (toggle != 3'b000);
    res.leds    = lock_leds ^ toggle;
  end

  always_comb begin
    shift_held_next = shift_held;
    unique case (code)
      scta_pkg::LSHIFT_ON:  shift_held_next = shift_held | 2'b01;
      scta_pkg::RSHIFT_ON:  shift_held_next = shift_held | 2'b10;
      scta_pkg::LSHIFT_OFF: shift_held_next = shift_held & 2'b10;
      scta_pkg::RSHIFT_OFF: shift_held_next = shift_held & 2'b01;
      default:              shift_held_next = shift_held;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 2'b00;
      lock_leds  <= 3'b000;
    end else if (cfg_we) begin
      lock_leds <= cfg_leds;
    end else if (take) begin
      shift_held <= shift_held_next;
      lock_leds  <= res.leds;
    end
  end

endmodule

@@ rtl/scta_out.sv @@
// ----------------------------------------------------------------------------
// scta_out: result register with a pending slot for the LED byte
// Takes a translation, shows the first byte, holds the second until free.
// ----------------------------------------------------------------------------
module scta_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  scta_pkg::res_t     res,
  output logic               take,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  logic       out_free;
  logic       p_valid;
  logic [2:0] p_leds;

  assign out_free = !m_tvalid || m_tready;
  assign take     = item_valid && out_free && !p_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      p_valid  <= 1'b0;
    end else if (out_free) begin
      if (p_valid) begin
        m_tvalid <= 1'b1;
        p_valid  <= 1'b0;
      end else if (take) begin
        m_tvalid <= res.char_ok || res.led_ok;
        p_valid  <= res.led_ok;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (p_valid) begin
        m_tdata <= {5'b00000, p_leds};
        m_tuser <= scta_pkg::KIND_LED;
        m_tlast <= 1'b1;
      end else if (take) begin
        if (res.led_ok) begin
          m_tdata <= scta_pkg::LED_CMD;
          m_tuser <= scta_pkg::KIND_LED;
          m_tlast <= 1'b0;
        end else begin
          m_tdata <= res.ch;
          m_tuser <= scta_pkg::KIND_CHAR;
          m_tlast <= 1'b1;
        end
        p_leds <= res.leds;
      end
    end
  end

  a_pend_behind_cmd : assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (m_tvalid && !m_tlast && m_tuser == scta_pkg::KIND_LED))
    else $error("pending LED byte without command byte in front");

  a_lock_two_bytes : assert property (@(posedge clk) disable iff (rst)
    (take && res.led_ok) |=> (p_valid && m_tvalid))
    else $error("lock key did not queue both LED bytes");

  a_no_take_pending : assert property (@(posedge clk) disable iff (rst)
    p_valid |-> !take)
    else $error("item taken while LED byte pending");

endmodule

@@ rtl/scancode_to_ascii_translator_unit.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator_unit: set-1 scan code to ASCII translator
// Keymap translation with shift, caps lock folding and lock LED commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one raw scan code byte per transfer.
//   Master stream (m_*) carries results: m_tdata is the character, the
//   LED command byte or the LED bits, m_tuser is the kind (0 character, 1 LED),
//   m_tlast marks the final result of one scan code.
//   cfg_* writes the lock LED bits (bit2 caps, bit1 num, bit0 scroll); the
//   write lands in the LED state at once. Write only while idle.
// Timing:
//   A scan code is registered in the input register on transfer, translated
//   from there combinationally, and its first result is registered in the
//   output register when the output side takes it, then shows on m_*.
//   Codes with one result or none sustain one transfer per cycle while m_tready
//   stays high. A lock key makes two results (0xED, then LED bits); while the
//   LED bits wait in the pending slot of the single output register, no code is
//   taken, so the next one waits in the input register and s_tready drops.
// Reset:
//   rst clears shift state, LED bits and both streams' valid flags.
// Stall:
//   When m_tready is low the result holds; one more code waits in the input
//   register, then s_tready drops until the result moves.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] scan_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] value
  output logic       m_tuser,   // [0] kind
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic           in_valid;
  logic [7:0]     in_code;
  logic           take;
  scta_pkg::res_t res;

  // Configuration is always taken and lands at once; write it only while idle.
  assign cfg_ready = 1'b1;

  // Accept a new code when the input register is empty or drains this cycle.
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  // Hold the payload until the translator takes it.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
    end
  end

  scta_translate u_translate (
    .clk      (clk),
    .rst      (rst),
    .code     (in_code),
    .take     (take),
    .cfg_we   (cfg_valid),
    .cfg_leds (cfg_data),
    .res      (res)
  );

  scta_out u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .res        (res),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
